[hdl/qsb_pkg.sv]
// ----------------------------------------------------------------------------
// qsb_pkg: shared types and constants of the slab histogram binner
// Request and result payloads, configuration record, command codes,
// sequencer states and controller/datapath interface groups.
// ----------------------------------------------------------------------------
package qsb_pkg;

    localparam int MAX_BINS_X_DEF = 256;
    localparam int MAX_BINS_Y_DEF = 256;

    localparam int BIN_W  = 48;
    localparam int HIT_W  = 32;
    localparam int PADDR_W = 5;

    // request command codes
    localparam logic [1:0] CMD_ACCUM = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SLAB_LOW  = 3'd0;
    localparam logic [2:0] REG_SLAB_HIGH = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
    localparam logic [2:0] REG_SCALE_X   = 3'd4;
    localparam logic [2:0] REG_SCALE_Y   = 3'd5;
    localparam logic [2:0] REG_BINS_X    = 3'd6;
    localparam logic [2:0] REG_BINS_Y    = 3'd7;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] q_slab;
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic [23:0]        pixel_count;
        logic [7:0]         read_x;
        logic [7:0]         read_y;
    } req_t;

    typedef struct packed {
        logic             binned;
        logic [7:0]       bin_x;
        logic [7:0]       bin_y;
        logic [BIN_W-1:0] bin_value;
        logic [HIT_W-1:0] hits_total;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] slab_low;
        logic signed [31:0] slab_high;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [8:0]         bins_x;
        logic [8:0]         bins_y;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ADDR,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic calc_diff;
        logic calc_mul;
        logic issue_read;
        logic sweep_write;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

[hdl/qsb_ram.sv]
// ----------------------------------------------------------------------------
// qsb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module qsb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/qsb_cfg.sv]
// ----------------------------------------------------------------------------
// qsb_cfg: configuration register file
// APB-style write and read access to the eight binning registers.
// ----------------------------------------------------------------------------
module qsb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qsb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output qsb_pkg::cfg_t               cfg
);

    qsb_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slab_low  <= '0;
            cfg_reg.slab_high <= '0;
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.scale_x   <= 32'd65536;
            cfg_reg.scale_y   <= 32'd65536;
            cfg_reg.bins_x    <= 9'd256;
            cfg_reg.bins_y    <= 9'd256;
        end
        else if (wr)
        begin
            case (idx)
                qsb_pkg::REG_SLAB_LOW:  cfg_reg.slab_low  <= pwdata;
                qsb_pkg::REG_SLAB_HIGH: cfg_reg.slab_high <= pwdata;
                qsb_pkg::REG_ORIGIN_X:  cfg_reg.origin_x  <= pwdata;
                qsb_pkg::REG_ORIGIN_Y:  cfg_reg.origin_y  <= pwdata;
                qsb_pkg::REG_SCALE_X:   cfg_reg.scale_x   <= pwdata;
                qsb_pkg::REG_SCALE_Y:   cfg_reg.scale_y   <= pwdata;
                qsb_pkg::REG_BINS_X:    cfg_reg.bins_x    <= pwdata[8:0];
                qsb_pkg::REG_BINS_Y:    cfg_reg.bins_y    <= pwdata[8:0];
                default:                cfg_reg.bins_y    <= cfg_reg.bins_y;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            qsb_pkg::REG_SLAB_LOW:  prdata = cfg_reg.slab_low;
            qsb_pkg::REG_SLAB_HIGH: prdata = cfg_reg.slab_high;
            qsb_pkg::REG_ORIGIN_X:  prdata = cfg_reg.origin_x;
            qsb_pkg::REG_ORIGIN_Y:  prdata = cfg_reg.origin_y;
            qsb_pkg::REG_SCALE_X:   prdata = cfg_reg.scale_x;
            qsb_pkg::REG_SCALE_Y:   prdata = cfg_reg.scale_y;
            qsb_pkg::REG_BINS_X:    prdata = {23'd0, cfg_reg.bins_x};
            qsb_pkg::REG_BINS_Y:    prdata = {23'd0, cfg_reg.bins_y};
            default:                prdata = '0;
        endcase
    end

endmodule

[hdl/qsb_ctrl.sv]
// ----------------------------------------------------------------------------
// qsb_ctrl: request sequencer
// Steps each non-clear request through difference, multiply, bin read and update,
// and runs the memory clearing sweep after reset and on a clear request.
// ----------------------------------------------------------------------------
module qsb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_command,
    output logic                req_ready,
    input  qsb_pkg::ctrl_stat_t stat,
    output qsb_pkg::ctrl_cmd_t  cmd
);

    qsb_pkg::state_t state_reg, state_next;
    logic            clr_pend_reg, clr_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qsb_pkg::ST_SWEEP;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        cmd           = '0;
        req_ready     = 1'b0;
        case (state_reg)
            qsb_pkg::ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = clr_pend_reg ? qsb_pkg::ST_UPDATE : qsb_pkg::ST_IDLE;
                end
            end
            qsb_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_command == qsb_pkg::CMD_CLEAR)
                    begin
                        state_next    = qsb_pkg::ST_SWEEP;
                        clr_pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next = qsb_pkg::ST_DIFF;
                    end
                end
            end
            qsb_pkg::ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = qsb_pkg::ST_MUL;
            end
            qsb_pkg::ST_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = qsb_pkg::ST_ADDR;
            end
            qsb_pkg::ST_ADDR:
            begin
                cmd.issue_read = 1'b1;
                state_next     = qsb_pkg::ST_UPDATE;
            end
            qsb_pkg::ST_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit    = 1'b1;
                    clr_pend_next = 1'b0;
                    state_next    = qsb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qsb_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed while output slot busy");

    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == qsb_pkg::ST_IDLE) && !clr_pend_reg)
        else $error("sequencer did not return to idle after commit");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_command == qsb_pkg::CMD_CLEAR)
        |=> (state_reg == qsb_pkg::ST_SWEEP) && clr_pend_reg)
        else $error("clear request did not start a sweep");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_write |-> !req_ready && !cmd.load)
        else $error("request taken during clearing sweep");

endmodule

[hdl/qsb_datapath.sv]
// ----------------------------------------------------------------------------
// qsb_datapath: binning arithmetic, bin memory and result register
// Computes slab test and bin indices, does the saturating read-modify-write
// of the bin memory and hit counter, and holds the pending result.
// ----------------------------------------------------------------------------
module qsb_datapath #(
    parameter int MAX_BINS_X = qsb_pkg::MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = qsb_pkg::MAX_BINS_Y_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qsb_pkg::cfg_t       cfg,
    input  qsb_pkg::req_t       req_data,
    input  qsb_pkg::ctrl_cmd_t  cmd,
    output qsb_pkg::ctrl_stat_t stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output qsb_pkg::rsp_t       rsp_data
);

    localparam int DEPTH  = MAX_BINS_X * MAX_BINS_Y;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] MBY  = ADDR_W'(MAX_BINS_Y);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);
    localparam logic [32:0] CAP_X = 33'(MAX_BINS_X);
    localparam logic [32:0] CAP_Y = 33'(MAX_BINS_Y);

    qsb_pkg::req_t    req_reg;
    logic             slab_ok_reg;
    logic [32:0]      mag_x_reg, mag_y_reg;
    logic [32:0]      ix_reg, iy_reg;
    logic             kept_reg, rd_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [qsb_pkg::HIT_W-1:0] hit_reg;
    qsb_pkg::rsp_t    rsp_reg;
    logic             rsp_valid_reg;

    logic [32:0]       dx, dy, mag_x, mag_y;
    logic [64:0]       px, py;
    logic [32:0]       bx, by;
    logic              kept, rd_ok;
    logic [ADDR_W-1:0] addr;
    logic [qsb_pkg::BIN_W-1:0] rdata, sum_sat;
    logic [qsb_pkg::BIN_W:0]   sum;
    logic [qsb_pkg::HIT_W-1:0] hit_inc;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [qsb_pkg::BIN_W-1:0] ram_wdata;
    qsb_pkg::rsp_t     rsp_new;

    // magnitudes of q - origin, exact in 33 bits, and their products with the scales
    always_comb
    begin
        dx    = {req_reg.q_x[31], req_reg.q_x} - {cfg.origin_x[31], cfg.origin_x};
        dy    = {req_reg.q_y[31], req_reg.q_y} - {cfg.origin_y[31], cfg.origin_y};
        mag_x = dx[32] ? (~dx + 33'd1) : dx;
        mag_y = dy[32] ? (~dy + 33'd1) : dy;
        px    = mag_x_reg * cfg.scale_x;
        py    = mag_y_reg * cfg.scale_y;
    end

    // bins in use, index check and memory address
    always_comb
    begin
        bx    = (33'(cfg.bins_x) < CAP_X) ? 33'(cfg.bins_x) : CAP_X;
        by    = (33'(cfg.bins_y) < CAP_Y) ? 33'(cfg.bins_y) : CAP_Y;
        kept  = (req_reg.command == qsb_pkg::CMD_ACCUM) && slab_ok_reg &&
                (ix_reg < bx) && (iy_reg < by);
        rd_ok = (33'(req_reg.read_x) < CAP_X) && (33'(req_reg.read_y) < CAP_Y);
        if (req_reg.command == qsb_pkg::CMD_READ)
        begin
            addr = ADDR_W'(req_reg.read_x) * MBY + ADDR_W'(req_reg.read_y);
        end
        else
        begin
            addr = ADDR_W'(ix_reg) * MBY + ADDR_W'(iy_reg);
        end
    end

    // saturating updates
    always_comb
    begin
        sum     = {1'b0, rdata} + 49'(req_reg.pixel_count);
        sum_sat = sum[qsb_pkg::BIN_W] ? '1 : sum[qsb_pkg::BIN_W-1:0];
        hit_inc = (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
    end

    always_comb
    begin
        rsp_new            = '0;
        rsp_new.hits_total = hit_reg;
        case (req_reg.command)
            qsb_pkg::CMD_ACCUM:
            begin
                if (kept_reg)
                begin
                    rsp_new.binned     = 1'b1;
                    rsp_new.bin_x      = ix_reg[7:0];
                    rsp_new.bin_y      = iy_reg[7:0];
                    rsp_new.bin_value  = sum_sat;
                    rsp_new.hits_total = hit_inc;
                end
            end
            qsb_pkg::CMD_READ:
            begin
                rsp_new.bin_x     = req_reg.read_x;
                rsp_new.bin_y     = req_reg.read_y;
                rsp_new.bin_value = rd_ok_reg ? rdata : '0;
            end
            qsb_pkg::CMD_CLEAR:
            begin
                rsp_new.hits_total = '0;
            end
            default:
            begin
                rsp_new.hits_total = hit_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.calc_diff)
        begin
            slab_ok_reg <= ($signed(req_reg.q_slab) >= $signed(cfg.slab_low)) &&
                           ($signed(req_reg.q_slab) <= $signed(cfg.slab_high));
            mag_x_reg   <= mag_x;
            mag_y_reg   <= mag_y;
        end
        if (cmd.calc_mul)
        begin
            ix_reg <= px[64:32];
            iy_reg <= py[64:32];
        end
        if (cmd.issue_read)
        begin
            kept_reg  <= kept;
            rd_ok_reg <= rd_ok;
            addr_reg  <= addr;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            hit_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep_write)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (req_reg.command == qsb_pkg::CMD_CLEAR)
                begin
                    hit_reg <= '0;
                end
                else if (kept_reg)
                begin
                    hit_reg <= hit_inc;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // a clear skips the bin read, so its kept flag belongs to an older request
    assign ram_we    = cmd.sweep_write ||
                       (cmd.commit && kept_reg && (req_reg.command == qsb_pkg::CMD_ACCUM));
    assign ram_waddr = cmd.sweep_write ? sweep_cnt_reg : addr_reg;
    assign ram_wdata = cmd.sweep_write ? '0 : sum_sat;

    qsb_ram #(
        .WIDTH (qsb_pkg::BIN_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue_read),
        .raddr (addr),
        .rdata (rdata)
    );

    assign stat.sweep_last = (sweep_cnt_reg == LAST);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_reg;

endmodule

[hdl/qspace_slab_histogram_binner_core.sv]
// ----------------------------------------------------------------------------
// qspace_slab_histogram_binner_core: 2D histogram of a q-space slab
// Top level: configuration registers, request sequencer and binning datapath.
// ----------------------------------------------------------------------------
// Every request produces exactly one result. An accumulate request keeps the
// pixel when q_slab lies in [slab_low, slab_high] and both in-plane indices
// floor(|q - origin| * scale) fall below min(bins, MAX_BINS); a kept pixel
// adds its count (saturating at 2^48-1) into its bin and bumps the saturating
// hit counter. A read request returns one bin; a clear request zeroes all
// bins and the counter. Accumulate, read and unused commands go from
// acceptance to result through accept, difference, multiply, bin read and
// update. The bin RAM read is registered ahead of its read-modify-write,
// and each axis has one 33x32 multiplier. A clear runs the sweep, which
// writes one bin per cycle, and then the update step. After reset the same
// sweep runs over all MAX_BINS_X*MAX_BINS_Y bins (65536 at the defaults)
// with req_ready low; register writes are taken throughout. A finished result
// waits in an output register, so the next request is accepted while it is
// still pending.
// Write registers only while the block is idle.
module qspace_slab_histogram_binner_core #(
    parameter int MAX_BINS_X = qsb_pkg::MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = qsb_pkg::MAX_BINS_Y_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        req_valid,
    output logic                        req_ready,
    input  qsb_pkg::req_t               req_data,
    // result channel
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output qsb_pkg::rsp_t               rsp_data,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qsb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    qsb_pkg::cfg_t       cfg;
    qsb_pkg::ctrl_cmd_t  cmd;
    qsb_pkg::ctrl_stat_t stat;

    // register file: hold binning setup
    qsb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: advance one request through its steps, run clearing sweeps
    qsb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req_data.command),
        .req_ready   (req_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // datapath: compute indices, update bins, hold the pending result
    qsb_datapath #(
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: request/result check of the q-space slab histogram binner
// Drives accumulate, read, clear and unused requests through the valid/ready
// channels under several register settings, predicts every result with an
// independent bin store and hit counter, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // A clear sweeps the whole grid with nothing accepted, so the quiet-cycle
    // limit must sit well above that sweep plus the long stall.
    localparam int     WATCHDOG_LIMIT = 200000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     HOLD_AT_ITEM   = 520;
    localparam int     DRAIN_CYCLES   = 20;
    localparam int     PHASES         = 6;
    localparam longint Q_MAX          = 64'sd2147483647;
    localparam longint Q_MIN          = -64'sd2147483648;

    // Predicted grid contents, hit counter and register copy, plus the
    // in-order list of results the block still owes us.
    class histogram_scoreboard;
        qsb_pkg::cfg_t cfg;
        logic [47:0]   bin_sums [int];
        logic [31:0]   hit_count;
        qsb_pkg::rsp_t bin_results_due [$];
        int            mismatches;
        int            results_seen;

        function new();
            cfg.slab_low  = '0;
            cfg.slab_high = '0;
            cfg.origin_x  = '0;
            cfg.origin_y  = '0;
            cfg.scale_x   = 32'h0001_0000;
            cfg.scale_y   = 32'h0001_0000;
            cfg.bins_x    = 9'd256;
            cfg.bins_y    = 9'd256;
            hit_count     = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                qsb_pkg::REG_SLAB_LOW:  cfg.slab_low  = value;
                qsb_pkg::REG_SLAB_HIGH: cfg.slab_high = value;
                qsb_pkg::REG_ORIGIN_X:  cfg.origin_x  = value;
                qsb_pkg::REG_ORIGIN_Y:  cfg.origin_y  = value;
                qsb_pkg::REG_SCALE_X:   cfg.scale_x   = value;
                qsb_pkg::REG_SCALE_Y:   cfg.scale_y   = value;
                qsb_pkg::REG_BINS_X:    cfg.bins_x    = value[8:0];
                qsb_pkg::REG_BINS_Y:    cfg.bins_y    = value[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned bins_in_use(logic [8:0] bins_reg, int unsigned cap);
            return (bins_reg < cap) ? int'(bins_reg) : cap;
        endfunction

        // floor(|q - origin| * scale) from the exact Q32.32 product
        function logic [31:0] axis_bin(logic signed [31:0] q, logic signed [31:0] org,
                                       logic [31:0] scl);
            longint      diff;
            logic [63:0] mag;
            logic [63:0] prod;
            diff = longint'(q) - longint'(org);
            mag  = (diff < 0) ? -diff : diff;
            prod = mag * {32'd0, scl};
            return prod[63:32];
        endfunction

        function logic [47:0] stored_sum(int key);
            return bin_sums.exists(key) ? bin_sums[key] : 48'd0;
        endfunction

        function void take_request(qsb_pkg::req_t r);
            qsb_pkg::rsp_t want;
            logic [31:0]   ix;
            logic [31:0]   iy;
            logic [48:0]   total;
            int            key;
            want            = '0;
            want.hits_total = hit_count;
            case (r.command)
                qsb_pkg::CMD_ACCUM:
                begin
                    if (r.q_slab >= cfg.slab_low && r.q_slab <= cfg.slab_high)
                    begin
                        ix = axis_bin(r.q_x, cfg.origin_x, cfg.scale_x);
                        iy = axis_bin(r.q_y, cfg.origin_y, cfg.scale_y);
                        if (ix < bins_in_use(cfg.bins_x, qsb_pkg::MAX_BINS_X_DEF) &&
                            iy < bins_in_use(cfg.bins_y, qsb_pkg::MAX_BINS_Y_DEF))
                        begin
                            key   = int'(ix) * qsb_pkg::MAX_BINS_Y_DEF + int'(iy);
                            total = {1'b0, stored_sum(key)} + {25'd0, r.pixel_count};
                            if (total[48])
                                total = {1'b0, {48{1'b1}}};
                            bin_sums[key] = total[47:0];
                            if (hit_count != '1)
                                hit_count = hit_count + 1;
                            want.binned     = 1'b1;
                            want.bin_x      = ix[7:0];
                            want.bin_y      = iy[7:0];
                            want.bin_value  = total[47:0];
                            want.hits_total = hit_count;
                        end
                    end
                end
                qsb_pkg::CMD_READ:
                begin
                    want.bin_x     = r.read_x;
                    want.bin_y     = r.read_y;
                    want.bin_value = stored_sum(int'(r.read_x) * qsb_pkg::MAX_BINS_Y_DEF +
                                                int'(r.read_y));
                end
                qsb_pkg::CMD_CLEAR:
                begin
                    bin_sums.delete();
                    hit_count       = '0;
                    want.hits_total = '0;
                end
                default: ;
            endcase
            bin_results_due.insert(bin_results_due.size(), want);
        endfunction

        function int outstanding();
            return bin_results_due.size();
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            if (mismatches < 200)
                $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h at %0t",
                         results_seen, field, got, want, $time);
            mismatches++;
        endtask

        task check_result(qsb_pkg::rsp_t got);
            qsb_pkg::rsp_t want;
            results_seen++;
            if (bin_results_due.size() == 0)
            begin
                report_mismatch("unexpected result", got.bin_value, 64'd0);
                return;
            end
            want = bin_results_due.pop_front();
            if (got.binned !== want.binned)
                report_mismatch("binned", got.binned, want.binned);
            if (got.bin_x !== want.bin_x)
                report_mismatch("bin_x", got.bin_x, want.bin_x);
            if (got.bin_y !== want.bin_y)
                report_mismatch("bin_y", got.bin_y, want.bin_y);
            if (got.bin_value !== want.bin_value)
                report_mismatch("bin_value", got.bin_value, want.bin_value);
            if (got.hits_total !== want.hits_total)
                report_mismatch("hits_total", got.hits_total, want.hits_total);
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_ready;
    qsb_pkg::req_t               req_data;
    logic                        rsp_valid;
    logic                        rsp_ready;
    qsb_pkg::rsp_t               rsp_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [qsb_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    histogram_scoreboard sb;
    int                  items_sent;
    int                  idle_mode;
    int                  clears_left;
    int unsigned         hot_x;
    int unsigned         hot_y;
    int                  quiet_cycles;
    bit                  hold_armed;
    bit                  hold_done;

    qspace_slab_histogram_binner_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle rates: sender-light/receiver-heavy, then swapped, then none.
    function automatic int unsigned sender_idle_pct();
        case (idle_mode)
            0:       return 19;
            1:       return 71;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_idle_pct();
        case (idle_mode)
            0:       return 71;
            1:       return 19;
            default: return 0;
        endcase
    endfunction

    // Result side: random back-pressure, with one long hold-off that lets
    // the pipeline fill and push back on the request channel.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                rsp_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Check every result at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
    end

    // Count cycles with no request or result accepted; bail out on a hang.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("qspace_slab_histogram_binner_core verification failed");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle; commit on pready.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_grid(input logic [31:0] slab_lo, input logic [31:0] slab_hi,
                                input logic [31:0] org_x, input logic [31:0] org_y,
                                input logic [31:0] scl_x, input logic [31:0] scl_y,
                                input logic [8:0] nbins_x, input logic [8:0] nbins_y);
        write_reg(qsb_pkg::REG_SLAB_LOW, slab_lo);
        write_reg(qsb_pkg::REG_SLAB_HIGH, slab_hi);
        write_reg(qsb_pkg::REG_ORIGIN_X, org_x);
        write_reg(qsb_pkg::REG_ORIGIN_Y, org_y);
        write_reg(qsb_pkg::REG_SCALE_X, scl_x);
        write_reg(qsb_pkg::REG_SCALE_Y, scl_y);
        write_reg(qsb_pkg::REG_BINS_X, {23'd0, nbins_x});
        write_reg(qsb_pkg::REG_BINS_Y, {23'd0, nbins_y});
    endtask

    // Drop valid for a random number of cycles before the next request.
    task automatic sender_gap();
        while ($urandom_range(99) < sender_idle_pct())
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input qsb_pkg::req_t r);
        sender_gap();
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_ready !== 1'b1);
        sb.take_request(r);
        items_sent++;
        idle_mode = (items_sent < 350) ? 0 : (items_sent < 700) ? 1 : 2;
        if (items_sent == HOLD_AT_ITEM)
            hold_armed = 1'b1;
    endtask

    task automatic send_directed(input logic [1:0] cmd, input logic [31:0] qs,
                                 input logic [31:0] qx, input logic [31:0] qy,
                                 input logic [23:0] count, input logic [7:0] rx,
                                 input logic [7:0] ry);
        qsb_pkg::req_t r;
        r.command     = cmd;
        r.q_slab      = qs;
        r.q_x         = qx;
        r.q_y         = qy;
        r.pixel_count = count;
        r.read_x      = rx;
        r.read_y      = ry;
        send_request(r);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Pick a q value whose index on this axis should land on the given bin.
    function automatic logic [31:0] aim_axis(logic signed [31:0] org, logic [31:0] scl,
                                             int unsigned bin);
        logic [63:0] target;
        logic [63:0] mag;
        longint      q;
        if (scl == 0)
            return $urandom;
        target = {bin, $urandom};
        mag    = target / {32'd0, scl};
        if (mag > 64'hFFFF_FFFF)
            return $urandom;
        q = $urandom_range(1) ? longint'(org) + longint'(mag) : longint'(org) - longint'(mag);
        if (q > Q_MAX || q < Q_MIN)
            q = 2 * longint'(org) - q;
        if (q > Q_MAX || q < Q_MIN)
            return $urandom;
        return q[31:0];
    endfunction

    // Mostly the phase's hot bin so sums build up; also the last bin, one
    // past the end, and anywhere in range.
    function automatic int unsigned pick_bin(logic [8:0] bins_reg, int unsigned cap,
                                             int unsigned hot);
        int unsigned lim;
        int unsigned roll;
        lim = sb.bins_in_use(bins_reg, cap);
        if (lim == 0)
            return $urandom_range(3);
        roll = $urandom_range(99);
        if (roll < 50)
            return hot;
        if (roll < 65)
            return $urandom_range(1) ? lim - 1 : lim;
        return $urandom_range(lim - 1);
    endfunction

    // Inside the slab mostly, with its bounds and the values just outside.
    function automatic logic [31:0] pick_slab();
        longint      lo;
        longint      hi;
        longint      q;
        int unsigned roll;
        lo   = sb.cfg.slab_low;
        hi   = sb.cfg.slab_high;
        roll = $urandom_range(99);
        if (lo > hi || roll < 5)
            return $urandom;
        if (roll < 10)
            return sb.cfg.slab_low;
        if (roll < 15)
            return sb.cfg.slab_high;
        if (roll < 18)
            return sb.cfg.slab_low - 32'd1;
        if (roll < 21)
            return sb.cfg.slab_high + 32'd1;
        q = lo + (longint'($urandom) % (hi - lo + 1));
        return q[31:0];
    endfunction

    function automatic qsb_pkg::req_t random_request();
        qsb_pkg::req_t r;
        int unsigned   roll;
        r.command     = qsb_pkg::CMD_ACCUM;
        r.q_slab      = $urandom;
        r.q_x         = $urandom;
        r.q_y         = $urandom;
        r.pixel_count = 24'($urandom);
        r.read_x      = 8'($urandom);
        r.read_y      = 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 10)
            r.pixel_count = '1;
        else if (roll < 15)
            r.pixel_count = '0;
        roll = $urandom_range(99);
        if (roll < 70 || (roll >= 96 && clears_left == 0))
        begin
            r.q_slab = pick_slab();
            r.q_x    = aim_axis(sb.cfg.origin_x, sb.cfg.scale_x,
                                pick_bin(sb.cfg.bins_x, qsb_pkg::MAX_BINS_X_DEF, hot_x));
            r.q_y    = aim_axis(sb.cfg.origin_y, sb.cfg.scale_y,
                                pick_bin(sb.cfg.bins_y, qsb_pkg::MAX_BINS_Y_DEF, hot_y));
        end
        else if (roll < 80)
        begin
            r.command = qsb_pkg::CMD_READ;
            if ($urandom_range(99) < 60)
            begin
                r.read_x = 8'(hot_x);
                r.read_y = 8'(hot_y);
            end
        end
        else if (roll < 93)
            r.command = qsb_pkg::CMD_ACCUM;
        else if (roll < 96)
            r.command = CMD_UNUSED;
        else
        begin
            r.command = qsb_pkg::CMD_CLEAR;
            clears_left--;
        end
        return r;
    endfunction

    // Register setting per phase: two corner settings, a one-value slab,
    // then random geometries.
    task automatic apply_setting(input int p);
        int unsigned lim;
        case (p)
            0: program_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0000_0000, 32'hFFFF_FFFF, 9'd1, 9'd256);
            1: program_grid(32'h0001_0000, 32'hFFFF_0000, $urandom, $urandom,
                            32'hFFFF_FFFF, 32'h0000_0000, 9'd0, 9'd511);
            2:
            begin
                lim = $urandom;
                program_grid(lim, lim, 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000,
                             32'($urandom_range(32'h0400_0000)) - 32'h0200_0000,
                             32'h0100_0000, 32'h0000_0100, 9'd256, 9'd2);
            end
            default:
                program_grid(32'd0 - $urandom_range(32'h0100_0000),
                             32'($urandom_range(32'h0100_0000)),
                             32'($urandom_range(32'h0400_0000)) - 32'h0200_0000,
                             32'($urandom_range(32'h0400_0000)) - 32'h0200_0000,
                             32'($urandom_range(32'h0040_0000, 32'h0000_0400)),
                             32'($urandom_range(32'h0040_0000, 32'h0000_0400)),
                             9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)));
        endcase
        lim   = sb.bins_in_use(sb.cfg.bins_x, qsb_pkg::MAX_BINS_X_DEF);
        hot_x = (lim == 0) ? 0 : $urandom_range(lim - 1);
        lim   = sb.bins_in_use(sb.cfg.bins_y, qsb_pkg::MAX_BINS_Y_DEF);
        hot_y = (lim == 0) ? 0 : $urandom_range(lim - 1);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        items_sent   = 0;
        idle_mode    = 0;
        clears_left  = 3;
        hot_x        = 0;
        hot_y        = 0;
        quiet_cycles = 0;
        hold_armed   = 1'b0;
        hold_done    = 1'b0;
        sb           = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: slab [-1.0, 1.0], unit scale, full grid. Registers are
        // taken during the power-up sweep; requests wait for ready.
        program_grid(32'hFFFF_0000, 32'h0001_0000, 32'd0, 32'd0,
                     32'h0001_0000, 32'h0001_0000, 9'd256, 9'd256);
        // slab bounds are inclusive; corner bins from both signs of q
        send_directed(qsb_pkg::CMD_ACCUM, 32'hFFFF_0000, 32'd0, 32'd0, 24'hFF_FFFF,
                      8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_ACCUM, 32'h0001_0000, 32'h00FF_FFFF, 32'hFF00_0001,
                      24'd1, 8'hFF, 8'hFF);
        // just outside the slab on each side
        send_directed(qsb_pkg::CMD_ACCUM, 32'hFFFE_FFFF, 32'd0, 32'd0, 24'd7, 8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_ACCUM, 32'h0001_0001, 32'd0, 32'd0, 24'd7, 8'd0, 8'd0);
        // index equal to the bin count, then the most distant q values
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h0100_0000, 32'd0, 24'd9, 8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 24'd9,
                      8'd0, 8'd0);
        // zero count still counts as a hit
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h00FF_0000, 32'd0, 24'd0, 8'd0, 8'd0);
        // back-to-back updates of one bin exercise the read-modify-write
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h0000_FFFF, 32'hFFFF_0001, 24'hFF_FFFF,
                      8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h0000_FFFF, 32'hFFFF_0001, 24'hFF_FFFF,
                      8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 24'd0, 8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      24'hFF_FFFF, 8'hFF, 8'hFF);
        send_directed(qsb_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 24'd0, 8'hFF, 8'd0);
        send_directed(qsb_pkg::CMD_READ, $urandom, $urandom, $urandom, 24'($urandom),
                      8'd17, 8'd200);
        send_directed(CMD_UNUSED, $urandom, $urandom, $urandom, 24'($urandom),
                      8'($urandom), 8'($urandom));
        send_directed(qsb_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 24'($urandom),
                      8'($urandom), 8'($urandom));
        send_directed(qsb_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 24'd0, 8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_ACCUM, 32'd0, 32'h0003_0000, 32'h0004_8000, 24'd5,
                      8'd0, 8'd0);
        send_directed(qsb_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 24'd0, 8'd3, 8'd4);
        settle();

        // Random phases; each one drains before its registers change.
        for (int p = 0; p < PHASES; p++)
        begin
            apply_setting(p);
            repeat ((p == 1) ? 40 : 200) send_request(random_request());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("qspace_slab_histogram_binner_core verification clean");
        else
            $display("qspace_slab_histogram_binner_core verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/qsb_pkg.sv
hdl/qsb_ram.sv
hdl/qsb_cfg.sv
hdl/qsb_ctrl.sv
hdl/qsb_datapath.sv
hdl/qspace_slab_histogram_binner_core.sv
tb/testbench.sv
